FILE: hw/rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// Lump packet deframer package
// Shared types, packet id codes, fault codes and the fixed length table.
// ----------------------------------------------------------------------------
package lpd_pkg;

  // Widths fixed by the word format.
  localparam int LEN_W          = 16;
  localparam int HDR_POS_W      = 4;
  localparam int COUNT_WIDTH_DEF = 16;

  // Ids at or above this count have no table entry.
  localparam int TABLE_ENTRIES  = 177;

  // Packet ids that need more than a table lookup.
  localparam logic [7:0] ID_CHAT    = 8'h26;
  localparam logic [7:0] ID_LEN16   = 8'h5b;
  localparam logic [7:0] ID_LEN3X   = 8'h94;
  localparam logic [7:0] ID_LEN_B6A = 8'ha8;
  localparam logic [7:0] ID_LEN_B6B = 8'haa;
  localparam logic [7:0] ID_LEN_B12 = 8'hac;
  localparam logic [7:0] ID_LEN16P3 = 8'hae;
  localparam logic [7:0] ID_LEN_B2A = 8'h9c;
  localparam logic [7:0] ID_LEN_B2B = 8'h9d;

  // Chat strings only count zero bytes from this packet position onwards.
  localparam int CHAT_BODY_POS = 10;

  // Fault codes.
  localparam logic [1:0] F_NONE = 2'd0;
  localparam logic [1:0] F_ID   = 2'd1;
  localparam logic [1:0] F_LEN  = 2'd2;
  localparam logic [1:0] F_MID  = 2'd3;

  // Fixed packet lengths; zero means the id has no fixed length.
  localparam logic [7:0] LEN_TABLE [TABLE_ENTRIES] = '{
    8'd1,  8'd8,  8'd1,  8'd12, 8'd1,  8'd1,  8'd1,  8'd6,
    8'd6,  8'd11, 8'd6,  8'd6,  8'd9,  8'd13, 8'd12, 8'd16,
    8'd16, 8'd8,  8'd26, 8'd14, 8'd18, 8'd11, 8'd0,  8'd0,
    8'd15, 8'd2,  8'd2,  8'd3,  8'd5,  8'd3,  8'd4,  8'd6,
    8'd10, 8'd12, 8'd12, 8'd13, 8'd90, 8'd90, 8'd0,  8'd40,
    8'd103, 8'd97, 8'd15, 8'd0, 8'd8,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd34, 8'd8,
    8'd13, 8'd0,  8'd6,  8'd0,  8'd0,  8'd13, 8'd0,  8'd11,
    8'd11, 8'd0,  8'd0,  8'd0,  8'd16, 8'd17, 8'd7,  8'd1,
    8'd15, 8'd14, 8'd42, 8'd10, 8'd3,  8'd0,  8'd0,  8'd14,
    8'd7,  8'd26, 8'd40, 8'd0,  8'd5,  8'd6,  8'd38, 8'd5,
    8'd7,  8'd2,  8'd7,  8'd21, 8'd0,  8'd7,  8'd7,  8'd16,
    8'd21, 8'd12, 8'd12, 8'd16, 8'd16, 8'd10, 8'd1,  8'd1,
    8'd1,  8'd1,  8'd1,  8'd32, 8'd10, 8'd13, 8'd6,  8'd2,
    8'd21, 8'd6,  8'd13, 8'd8,  8'd6,  8'd18, 8'd5,  8'd10,
    8'd4,  8'd20, 8'd29, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd2,  8'd6,  8'd6,  8'd11, 8'd7,  8'd10, 8'd33,
    8'd13, 8'd26, 8'd6,  8'd8,  8'd0,  8'd13, 8'd9,  8'd1,
    8'd7,  8'd16, 8'd17, 8'd7,  8'd0,  8'd0,  8'd7,  8'd8,
    8'd10, 8'd7,  8'd8,  8'd24, 8'd3,  8'd8,  8'd0,  8'd7,
    8'd0,  8'd7,  8'd0,  8'd7,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd1
  };

  // Input word.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       lump_last;
  } lpd_in_t;

  // Result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       pkt_first;
    logic       pkt_last;
    logic       lump_done;
    logic       lump_good;
    logic [1:0] fault;
  } lpd_out_t;

  // Fixed length of an id, zero when it has none.
  function automatic logic [7:0] fixed_len(input logic [7:0] id);
    logic [7:0] len;
    len = 8'd0;
    if (int'(id) < TABLE_ENTRIES) begin
      len = LEN_TABLE[id];
    end
    return len;
  endfunction

  // Position of the byte that completes the length header, zero if none.
  function automatic logic [HDR_POS_W-1:0] header_pos(input logic [7:0] id);
    logic [HDR_POS_W-1:0] pos;
    case (id)
      ID_LEN3X:                                     pos = 4'd1;
      ID_LEN16, ID_LEN16P3, ID_LEN_B2A, ID_LEN_B2B: pos = 4'd2;
      ID_LEN_B6A, ID_LEN_B6B:                       pos = 4'd6;
      ID_LEN_B12:                                   pos = 4'd12;
      default:                                      pos = 4'd0;
    endcase
    return pos;
  endfunction

endpackage

FILE: hw/rtl/lpd_in_if.sv
// ----------------------------------------------------------------------------
// Lump byte input channel
// Valid/ready channel that carries one lump byte and its end-of-lump mark.
// ----------------------------------------------------------------------------
interface lpd_in_if;
  logic             valid;
  logic             ready;
  lpd_pkg::lpd_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/lpd_out_if.sv
// ----------------------------------------------------------------------------
// Deframer result channel
// Valid/ready channel that carries one marked byte and the lump status.
// ----------------------------------------------------------------------------
interface lpd_out_if;
  logic              valid;
  logic              ready;
  lpd_pkg::lpd_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/lump_packet_deframer.sv
// ----------------------------------------------------------------------------
// Lump packet deframer
// Marks packet boundaries in a decompressed lump byte stream.
// ----------------------------------------------------------------------------
// The block takes one lump byte per cycle and returns it in the next cycle,
// marked where a packet opens and where it completes. Each accepted word
// gives exactly one result word; the lump's last byte also carries whether
// the lump split cleanly and, if not, its first fault. A single output
// register parts the two sides: input ready is high whenever that register
// is empty or being emptied in the same cycle, so a sustained rate of one
// word per clock holds as long as the result side takes its words.
module lump_packet_deframer #(
  parameter int COUNT_WIDTH = lpd_pkg::COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lpd_in_if.sink    in_s,
  lpd_out_if.source out_s
);
  import lpd_pkg::*;

  logic     accept;
  lpd_out_t res;
  logic     out_valid_r;
  lpd_out_t out_data_r;

  assign in_s.ready = !out_valid_r || out_s.ready;
  assign accept     = in_s.valid && in_s.ready;

  lpd_parse_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (accept),
    .in_word (in_s.data),
    .res     (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_s.valid = out_valid_r;
  assign out_s.data  = out_data_r;

  // A good lump report carries no fault.
  a_good_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.lump_good |->
      out_data_r.lump_done && out_data_r.fault == F_NONE)
    else $error("good lump reported with a fault");

  // A byte that opens a packet cannot carry an id or length fault.
  a_first_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.pkt_first |->
      out_data_r.fault != F_ID && out_data_r.fault != F_LEN)
    else $error("packet opened on a faulty byte");

  // Each accepted word appears as the next result.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r && out_data_r.out_byte == $past(in_s.data.in_byte))
    else $error("result does not follow accepted word");

endmodule

FILE: hw/rtl/lpd_parse_core.sv
// ----------------------------------------------------------------------------
// Lump packet parser
// Holds the packet tracking state and works out the marks for each word.
// ----------------------------------------------------------------------------
module lpd_parse_core #(
  parameter int COUNT_WIDTH = lpd_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  lpd_pkg::lpd_in_t  in_word,
  output lpd_pkg::lpd_out_t res
);
  import lpd_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_FIXED  = 3'd1;
  localparam logic [2:0] PH_HEADER = 3'd2;
  localparam logic [2:0] PH_CHAT   = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;

  localparam int CMP_W = COUNT_WIDTH + 1;
  localparam int SLEN_W = LEN_W + 2;

  logic [2:0]             phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] pos_r, pos_nxt, pos_inc;
  logic [LEN_W-1:0]       exp_len_r, exp_len_nxt;
  logic [7:0]             cur_id_r, cur_id_nxt;
  logic [7:0]             len_low_r, len_low_nxt;
  logic                   chat_zero_r, chat_zero_nxt;
  logic                   failed_r, failed_nxt;
  logic [1:0]             first_fault_r, first_fault_nxt;

  logic [7:0]             b;
  logic [7:0]             tab_len;
  logic [HDR_POS_W-1:0]   hp;
  logic signed [SLEN_W-1:0] len_s, raw_s, hdr_end_s;
  logic [1:0]             flt;
  logic                   first, plast;

  assign b       = in_word.in_byte;
  assign tab_len = fixed_len(b);
  assign hp      = header_pos(cur_id_r);
  assign pos_inc = (pos_r == {COUNT_WIDTH{1'b1}}) ? pos_r : pos_r + 1'b1;

  // Length carried by the header, as a signed value wide enough for all forms.
  always_comb begin
    raw_s     = signed'({{2{b[7]}}, b, len_low_r});
    hdr_end_s = signed'(SLEN_W'(hp) + SLEN_W'(1));
    case (cur_id_r)
      ID_LEN3X:   len_s = signed'(SLEN_W'({b, 1'b0}) + SLEN_W'(b) + SLEN_W'(6));
      ID_LEN16:   len_s = raw_s;
      ID_LEN16P3: len_s = raw_s + SLEN_W'(3);
      default:    len_s = signed'(SLEN_W'(b));
    endcase
  end

  // Per-byte packet tracking.
  always_comb begin
    phase_nxt       = phase_r;
    pos_nxt         = pos_r;
    exp_len_nxt     = exp_len_r;
    cur_id_nxt      = cur_id_r;
    len_low_nxt     = len_low_r;
    chat_zero_nxt   = chat_zero_r;
    failed_nxt      = failed_r;
    first_fault_nxt = first_fault_r;
    flt             = F_NONE;
    first           = 1'b0;
    plast           = 1'b0;

    case (phase_r)
      PH_IDLE: begin
        cur_id_nxt    = b;
        pos_nxt       = '0;
        exp_len_nxt   = '0;
        chat_zero_nxt = 1'b0;
        if (b == ID_CHAT) begin
          first     = 1'b1;
          phase_nxt = PH_CHAT;
        end else if (header_pos(b) != '0) begin
          first     = 1'b1;
          phase_nxt = PH_HEADER;
        end else if (tab_len != 8'd0) begin
          first       = 1'b1;
          exp_len_nxt = LEN_W'(tab_len);
          if (tab_len == 8'd1) begin
            plast = 1'b1;
          end else begin
            phase_nxt = PH_FIXED;
          end
        end else begin
          flt = F_ID;
        end
      end
      PH_FIXED: begin
        pos_nxt = pos_inc;
        if (CMP_W'(pos_inc) + CMP_W'(1) >= CMP_W'(exp_len_r)) begin
          plast     = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      PH_CHAT: begin
        pos_nxt = pos_inc;
        if (pos_inc >= COUNT_WIDTH'(CHAT_BODY_POS) && b == 8'd0) begin
          if (chat_zero_r) begin
            plast     = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            chat_zero_nxt = 1'b1;
          end
        end
      end
      PH_HEADER: begin
        pos_nxt = pos_inc;
        if (pos_inc == COUNT_WIDTH'(1)) begin
          len_low_nxt = b;
        end
        if (pos_inc == COUNT_WIDTH'(hp)) begin
          if (len_s < hdr_end_s) begin
            flt = F_LEN;
          end else if (len_s == hdr_end_s) begin
            plast     = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            exp_len_nxt = len_s[LEN_W-1:0];
            phase_nxt   = PH_FIXED;
          end
        end
      end
      default: begin
        phase_nxt = PH_SKIP;
      end
    endcase

    // A fault skips the rest of the lump; only the first one is kept.
    if (flt != F_NONE) begin
      if (!failed_r) begin
        failed_nxt      = 1'b1;
        first_fault_nxt = flt;
      end
      phase_nxt = PH_SKIP;
    end

    res.out_byte  = b;
    res.pkt_first = first;
    res.pkt_last  = plast;
    res.lump_done = in_word.lump_last;
    res.lump_good = 1'b0;
    res.fault     = flt;

    // The lump's final byte reports its status and starts a fresh lump.
    if (in_word.lump_last) begin
      if (!failed_nxt && phase_nxt != PH_IDLE) begin
        failed_nxt      = 1'b1;
        first_fault_nxt = F_MID;
      end
      res.lump_good   = !failed_nxt;
      res.fault       = first_fault_nxt;
      phase_nxt       = PH_IDLE;
      failed_nxt      = 1'b0;
      first_fault_nxt = F_NONE;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      failed_r      <= 1'b0;
      first_fault_r <= F_NONE;
    end else if (step) begin
      phase_r       <= phase_nxt;
      failed_r      <= failed_nxt;
      first_fault_r <= first_fault_nxt;
    end
  end

  // Packet working registers, updated on every accepted word.
  always_ff @(posedge clk) begin
    if (step) begin
      pos_r       <= pos_nxt;
      exp_len_r   <= exp_len_nxt;
      cur_id_r    <= cur_id_nxt;
      len_low_r   <= len_low_nxt;
      chat_zero_r <= chat_zero_nxt;
    end
  end

  // A skipped lump has always recorded its fault.
  a_skip_failed: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> failed_r && first_fault_r != F_NONE)
    else $error("skipping without a recorded fault");

  // Every lump starts from a clean state.
  a_lump_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && in_word.lump_last |=> phase_r == PH_IDLE && !failed_r)
    else $error("lump state not cleared after last byte");

  // Only the idle phase accepts a packet id.
  a_first_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res.pkt_first |-> phase_r == PH_IDLE)
    else $error("packet opened outside the idle phase");

endmodule
